// ===== rtl/lrhb_pkg.sv =====
// Types, constants and CRC helpers shared by the log record header builder.
package lrhb_pkg;

   localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
   localparam logic [31:0] CRC_ONES   = 32'hFFFFFFFF;
   localparam logic [7:0]  KIND_EXP_A = 8'h05;
   localparam logic [7:0]  KIND_EXP_B = 8'h07;

   localparam int HDR_BASE   = 11;
   localparam int HDR_EXT    = HDR_BASE + 4;
   localparam int HDR_IDX_W  = $clog2(HDR_EXT);
   localparam int HDR_BITS   = 8 * HDR_EXT;

   localparam int Q_DEPTH    = 4;
   localparam int Q_PTR_W    = $clog2(Q_DEPTH);
   localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

   // Expiry CRC precompute stages ahead of the record state.
   localparam int PIPE_DEPTH = 4;

   typedef struct packed {
      logic        first;
      logic [7:0]  op;
      logic [31:0] expiry;
      logic        has_byte;
      logic        in_value;
      logic [7:0]  data_byte;
      logic        last;
   } req_word_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
   } rsp_word_type;

   // Packed so that bits [7:0] hold header byte 0 and so on upward.
   typedef struct packed {
      logic [31:0] expiry;
      logic [31:0] crc;
      logic [31:0] value_count;
      logic [15:0] key_count;
      logic [7:0]  kind;
   } hdr_desc_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
      logic [31:0] c;
      c = c_in ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
      end
      return c;
   endfunction

   function automatic logic kind_has_expiry(input logic [7:0] kind);
      return (kind == KIND_EXP_A) || (kind == KIND_EXP_B);
   endfunction

endpackage

// ===== rtl/lrhb_front.sv =====
// Front end: expiry CRC precompute pipeline and running record state.
module lrhb_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  lrhb_pkg::req_word_type in_word,
   input  lrhb_pkg::q_status_type q_status,
   output logic                  push,
   output lrhb_pkg::hdr_desc_type push_desc
);

   localparam int N = lrhb_pkg::PIPE_DEPTH;

   logic                   p_v_ff [N];
   logic                   p_v_in [N];
   lrhb_pkg::req_word_type p_ff   [N];
   logic [31:0]            e_ff   [N];
   logic [31:0]            e_in   [N];

   logic [31:0] crc_ff,   crc_in;
   logic [15:0] kcnt_ff,  kcnt_in;
   logic [31:0] vcnt_ff,  vcnt_in;
   logic [7:0]  kind_ff,  kind_in;
   logic [31:0] exp_ff,   exp_in;

   logic        en;
   logic        do_step;
   logic [31:0] crc_base;
   lrhb_pkg::req_word_type tail;

   assign tail     = p_ff[N-1];
   // Only a header push can be blocked, and only by a full queue.
   assign en       = !(p_v_ff[N-1] && tail.last && q_status.full);
   assign in_ready = en;
   assign do_step  = en && p_v_ff[N-1];

   always_comb begin
      p_v_in[0] = in_valid;
      e_in[0]   = lrhb_pkg::crc_byte(lrhb_pkg::CRC_ONES, in_word.expiry[7:0]);
      for (int k = 1; k < N; k++) begin
         p_v_in[k] = p_v_ff[k-1];
         e_in[k]   = lrhb_pkg::crc_byte(e_ff[k-1], p_ff[k-1].expiry[8*k +: 8]);
      end
   end

   always_comb begin
      crc_in  = crc_ff;
      kcnt_in = kcnt_ff;
      vcnt_in = vcnt_ff;
      kind_in = kind_ff;
      exp_in  = exp_ff;
      if (tail.first) begin
         kind_in = tail.op;
         exp_in  = tail.expiry;
         kcnt_in = '0;
         vcnt_in = '0;
         crc_base = lrhb_pkg::kind_has_expiry(tail.op) ? e_ff[N-1] : lrhb_pkg::CRC_ONES;
      end else begin
         crc_base = crc_ff;
      end
      crc_in = crc_base;
      if (tail.has_byte) begin
         crc_in = lrhb_pkg::crc_byte(crc_base, tail.data_byte);
         if (tail.in_value) begin
            vcnt_in = vcnt_in + 32'd1;
         end else begin
            kcnt_in = kcnt_in + 16'd1;
         end
      end
   end

   assign push                  = do_step && tail.last;
   assign push_desc.kind        = kind_in;
   assign push_desc.key_count   = kcnt_in;
   assign push_desc.value_count = vcnt_in;
   assign push_desc.crc         = crc_in ^ lrhb_pkg::CRC_ONES;
   assign push_desc.expiry      = exp_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < N; k++) begin
            p_v_ff[k] <= 1'b0;
         end
         crc_ff  <= lrhb_pkg::CRC_ONES;
         kcnt_ff <= '0;
         vcnt_ff <= '0;
         kind_ff <= '0;
         exp_ff  <= '0;
      end else if (en) begin
         for (int k = 0; k < N; k++) begin
            p_v_ff[k] <= p_v_in[k];
         end
         if (do_step) begin
            crc_ff  <= crc_in;
            kcnt_ff <= kcnt_in;
            vcnt_ff <= vcnt_in;
            kind_ff <= kind_in;
            exp_ff  <= exp_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff[0] <= in_word;
         for (int k = 1; k < N; k++) begin
            p_ff[k] <= p_ff[k-1];
         end
         for (int k = 0; k < N; k++) begin
            e_ff[k] <= e_in[k];
         end
      end
   end

endmodule

// ===== rtl/lrhb_queue.sv =====
// Short FIFO of pending header descriptors between front and back.
module lrhb_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  lrhb_pkg::hdr_desc_type push_desc,
   input  logic                   pop,
   output lrhb_pkg::hdr_desc_type head,
   output lrhb_pkg::q_status_type status
);

   localparam int D  = lrhb_pkg::Q_DEPTH;
   localparam int PW = lrhb_pkg::Q_PTR_W;
   localparam int CW = lrhb_pkg::Q_CNT_W;

   lrhb_pkg::hdr_desc_type slot_ff [D];
   logic [PW-1:0] wr_ff, wr_in;
   logic [PW-1:0] rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   assign head         = slot_ff[rd_ff];
   assign status.full  = (cnt_ff == CW'(D));
   assign status.empty = (cnt_ff == '0);

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(D - 1)) ? '0 : wr_ff + PW'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == PW'(D - 1)) ? '0 : rd_ff + PW'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_desc;
      end
   end

endmodule

// ===== rtl/lrhb_back.sv =====
// Back end: serializes one header descriptor into header bytes.
module lrhb_back (
   input  logic                   clock,
   input  logic                   reset,
   input  lrhb_pkg::hdr_desc_type head,
   input  lrhb_pkg::q_status_type q_status,
   output logic                   pop,
   output logic                   out_valid,
   input  logic                   out_ready,
   output lrhb_pkg::rsp_word_type out_word
);

   localparam int IW = lrhb_pkg::HDR_IDX_W;

   logic                   busy_ff, busy_in;
   lrhb_pkg::hdr_desc_type desc_ff, desc_in;
   logic [IW-1:0]          idx_ff,  idx_in;
   logic                   ov_ff,   ov_in;
   lrhb_pkg::rsp_word_type ow_ff,   ow_in;

   logic [lrhb_pkg::HDR_BITS-1:0] hdr_bits;
   logic [IW-1:0] last_idx;
   logic          out_free, emit, last_byte, done, load;

   assign hdr_bits  = desc_ff;
   assign last_idx  = lrhb_pkg::kind_has_expiry(desc_ff.kind) ? IW'(lrhb_pkg::HDR_EXT - 1)
                                                              : IW'(lrhb_pkg::HDR_BASE - 1);
   assign out_free  = !ov_ff || out_ready;
   assign emit      = busy_ff && out_free;
   assign last_byte = (idx_ff == last_idx);
   assign done      = emit && last_byte;
   assign load      = (!busy_ff || done) && !q_status.empty;
   assign pop       = load;

   always_comb begin
      busy_in = busy_ff;
      desc_in = desc_ff;
      idx_in  = idx_ff;
      ov_in   = ov_ff;
      ow_in   = ow_ff;
      if (done) begin
         busy_in = 1'b0;
      end
      if (emit) begin
         idx_in         = idx_ff + IW'(1);
         ov_in          = 1'b1;
         ow_in.out_byte = hdr_bits[{idx_ff, 3'b000} +: 8];
         ow_in.out_last = last_byte;
      end else if (out_ready) begin
         ov_in = 1'b0;
      end
      if (load) begin
         busy_in = 1'b1;
         desc_in = head;
         idx_in  = '0;
      end
   end

   assign out_valid = ov_ff;
   assign out_word  = ow_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
         ov_ff   <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
         ov_ff   <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      desc_ff <= desc_in;
      ow_ff   <= ow_in;
   end

endmodule

// ===== rtl/log_record_header_builder_top.sv =====
// Log record header builder: CRC-32 and length framing of streamed records.
// Throughput: one req word per cycle while req_ready is high; header output one
//   rsp word per cycle while rsp_ready is high. With the queue and back end
//   idle, the last accepted word of a record reaches rsp as header byte 0 via
//   three more expiry CRC stages, queue write, descriptor load, output register.
// req_ready drops only while a finished header waits on a full descriptor queue.
// Reset (synchronous): CRC all ones, counts, kind and expiry zero, queue empty.
module log_record_header_builder_top (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  lrhb_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output lrhb_pkg::rsp_word_type rsp_word
);

   // Descriptor handoff between the record front end and the byte serializer.
   logic                   q_push;
   logic                   q_pop;
   lrhb_pkg::hdr_desc_type q_push_desc;
   lrhb_pkg::hdr_desc_type q_head;
   lrhb_pkg::q_status_type q_status;

   // Front: precomputes the expiry CRC off the record state path, then folds
   // each payload byte into the running CRC and counts; pushes on last.
   lrhb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_word   (req_word),
      .q_status  (q_status),
      .push      (q_push),
      .push_desc (q_push_desc)
   );

   // Queue lets several short records finish while a long header drains.
   lrhb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (q_push_desc),
      .pop       (q_pop),
      .head      (q_head),
      .status    (q_status)
   );

   // Back: 11 or 15 header bytes per descriptor, registered output word.
   lrhb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (q_head),
      .q_status  (q_status),
      .pop       (q_pop),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_word  (rsp_word)
   );

endmodule

// ===== sim/lrhb_tb_pkg.sv =====
// Testbench package: header prediction and checking for the log record header builder.
package lrhb_tb_pkg;
   import lrhb_pkg::*;

   class record_framer;
      logic [31:0]  crc_reg;
      logic [15:0]  key_len;
      logic [31:0]  value_len;
      logic [7:0]   kind_reg;
      logic [31:0]  expiry_reg;
      rsp_word_type header_due[$];
      int unsigned  fail_count;
      int unsigned  words_seen;
      int unsigned  headers_built;
      int unsigned  bytes_checked;

      function new();
         crc_reg       = CRC_ONES;
         key_len       = '0;
         value_len     = '0;
         kind_reg      = '0;
         expiry_reg    = '0;
         fail_count    = 0;
         words_seen    = 0;
         headers_built = 0;
         bytes_checked = 0;
      endfunction

      // reflected CRC-32, one data bit per step, LSB first
      function logic [31:0] crc_step(logic [31:0] acc, logic [7:0] b);
         logic [31:0] c;
         logic        fb;
         c = acc;
         for (int k = 0; k < 8; k++) begin
            fb = c[0] ^ b[k];
            c  = {1'b0, c[31:1]} ^ (fb ? CRC_POLY : 32'h0);
         end
         return c;
      endfunction

      function int pending();
         return header_due.size();
      endfunction

      // fold one accepted req word into the state, queue header bytes on last
      function void absorb_word(req_word_type w);
         logic [8*HDR_EXT-1:0] hdr_bits;
         rsp_word_type         e;
         bit                   with_expiry;
         int                   n;
         words_seen++;
         if (w.first) begin
            kind_reg   = w.op;
            expiry_reg = w.expiry;
            crc_reg    = CRC_ONES;
            key_len    = '0;
            value_len  = '0;
            if (kind_reg == KIND_EXP_A || kind_reg == KIND_EXP_B) begin
               for (int i = 0; i < 4; i++) crc_reg = crc_step(crc_reg, expiry_reg[8*i +: 8]);
            end
         end
         if (w.has_byte) begin
            crc_reg = crc_step(crc_reg, w.data_byte);
            if (w.in_value) value_len = value_len + 32'd1;
            else            key_len   = key_len + 16'd1;
         end
         if (!w.last) return;
         with_expiry = (kind_reg == KIND_EXP_A || kind_reg == KIND_EXP_B);
         hdr_bits    = {expiry_reg, crc_reg ^ CRC_ONES, value_len, key_len, kind_reg};
         n           = with_expiry ? HDR_EXT : HDR_BASE;
         for (int i = 0; i < n; i++) begin
            e.out_byte = hdr_bits[8*i +: 8];
            e.out_last = (i == n - 1);
            header_due.push_back(e);
         end
         headers_built++;
      endfunction

      // compare one accepted rsp word with the oldest queued header byte
      function void match_byte(rsp_word_type got, time stamp);
         rsp_word_type want;
         if (header_due.size() == 0) begin
            fail_count++;
            $display("%0t: stray header byte: expected none, actual byte %02h last %0b",
                     stamp, got.out_byte, got.out_last);
            return;
         end
         want = header_due.pop_front();
         bytes_checked++;
         if (got.out_byte !== want.out_byte) begin
            fail_count++;
            $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                     stamp, want.out_byte, got.out_byte);
         end
         if (got.out_last !== want.out_last) begin
            fail_count++;
            $display("%0t: out_last mismatch: expected %0b, actual %0b",
                     stamp, want.out_last, got.out_last);
         end
      endfunction
   endclass

endpackage

// ===== sim/tb_log_record_header_builder_top.sv =====
// Top-level testbench for the log record header builder: stimulus, handshakes, final verdict.
module tb_log_record_header_builder_top;
   timeunit 1ns;
   timeprecision 1ps;

   import lrhb_pkg::*;
   import lrhb_tb_pkg::*;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_word_type req_word  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_word_type rsp_word;

   record_framer framer;

   // idle odds in percent per cycle, per side
   int unsigned  send_idle_pct = 0;
   int unsigned  recv_idle_pct = 0;
   int unsigned  words_sent    = 0;

   log_record_header_builder_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // hard stop; slowest legal run is well under a millisecond
   initial begin
      #5_000_000;
      $display("timeout at %0t, %0d header bytes still due", $time, framer.pending());
      $display("[FAIL] regression broken");
      $finish;
   end

   // receiver: ready changes on the falling edge only, held low in reset
   initial begin
      forever begin
         @(negedge clock);
         if (!reset) rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // every rsp word accepted at a rising edge goes to the checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) framer.match_byte(rsp_word, $time);
   end

   function automatic req_word_type mk_word(bit first, logic [7:0] op, logic [31:0] expiry,
                                            bit has_byte, bit in_value, logic [7:0] data,
                                            bit last);
      req_word_type w;
      w.first     = first;
      w.op        = op;
      w.expiry    = expiry;
      w.has_byte  = has_byte;
      w.in_value  = in_value;
      w.data_byte = data;
      w.last      = last;
      return w;
   endfunction

   // payload word; op and expiry carry random junk since only first latches them
   function automatic req_word_type byte_word(bit in_value);
      return mk_word(1'b0, 8'($urandom_range(255)), $urandom(), 1'b1, in_value,
                     8'($urandom_range(255)), 1'b0);
   endfunction

   // word with no payload; in_value and data are noise the block must ignore
   function automatic req_word_type empty_word();
      return mk_word(1'b0, 8'($urandom_range(255)), $urandom(), 1'b0, 1'($urandom_range(1)),
                     8'($urandom_range(255)), 1'b0);
   endfunction

   // Drive one req word. Called right after a falling edge; returns after the
   // falling edge that follows its acceptance so valid can stay high into the following word.
   task automatic send_word(req_word_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_word  <= empty_word();
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (!req_ready);
      framer.absorb_word(w);
      words_sent++;
      @(negedge clock);
   endtask

   // Mostly well-formed records with random content; a few lack a start,
   // carry empty words, or put a key byte after the value bytes.
   task automatic send_random_record();
      req_word_type q[$];
      req_word_type w;
      logic [7:0]   kind;
      int           nkey;
      int           nval;
      if ($urandom_range(99) < 40) kind = $urandom_range(1) ? KIND_EXP_A : KIND_EXP_B;
      else                         kind = 8'($urandom_range(255));
      w = mk_word(($urandom_range(99) >= 8), kind, $urandom(), 1'b0, 1'($urandom_range(1)),
                  8'($urandom_range(255)), 1'b0);
      if ($urandom_range(1)) begin
         w.has_byte = 1'b1;
         w.in_value = 1'b0;
      end
      q.push_back(w);
      nkey = $urandom_range(5);
      nval = $urandom_range(6);
      for (int i = 0; i < nkey; i++) q.push_back(byte_word(1'b0));
      if ($urandom_range(99) < 20) q.push_back(empty_word());
      for (int i = 0; i < nval; i++) q.push_back(byte_word(1'b1));
      if ($urandom_range(99) < 15) q.push_back(byte_word(1'b0));
      // last either rides on the final byte or on a word of its own
      if ($urandom_range(3) == 0) q.push_back(empty_word());
      w = q.pop_back();
      w.last = 1'b1;
      q.push_back(w);
      foreach (q[i]) send_word(q[i]);
      // stray words between records extend the finished record's state
      if ($urandom_range(99) < 10) send_word(byte_word(1'($urandom_range(1))));
   endtask

   task automatic run_random(int unsigned n_words);
      int unsigned start;
      start = words_sent;
      while (words_sent - start < n_words) send_random_record();
   endtask

   task automatic send_directed();
      // bytes and a header with no record start: built on the reset state
      send_word(mk_word(1'b0, 8'h00, 32'h0000_0000, 1'b1, 1'b0, 8'hA5, 1'b0));
      send_word(mk_word(1'b0, 8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 8'hFF, 1'b1));
      // expiry kind 05, all-ones expiry, extreme data bytes
      send_word(mk_word(1'b1, KIND_EXP_A, 32'hFFFF_FFFF, 1'b1, 1'b0, 8'h00, 1'b0));
      send_word(mk_word(1'b0, 8'h00, 32'h0000_0000, 1'b1, 1'b1, 8'hFF, 1'b0));
      send_word(mk_word(1'b0, 8'h00, 32'h0000_0000, 1'b1, 1'b1, 8'h80, 1'b1));
      // expiry kind 07, zero expiry, empty record in a single word
      send_word(mk_word(1'b1, KIND_EXP_B, 32'h0000_0000, 1'b0, 1'b1, 8'hFF, 1'b1));
      // kind FF: key after value, payload fields ignored with has_byte clear
      send_word(mk_word(1'b1, 8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 8'hFF, 1'b0));
      send_word(mk_word(1'b0, 8'h00, 32'h0000_0000, 1'b1, 1'b1, 8'h01, 1'b0));
      send_word(mk_word(1'b0, 8'h00, 32'h0000_0000, 1'b1, 1'b0, 8'h7E, 1'b0));
      send_word(mk_word(1'b0, 8'h12, 32'hDEAD_BEEF, 1'b0, 1'b1, 8'hFF, 1'b0));
      send_word(mk_word(1'b0, 8'h00, 32'h0000_0000, 1'b0, 1'b0, 8'h00, 1'b1));
      // kinds next to the expiry kinds carry no expiry
      send_word(mk_word(1'b1, 8'h06, 32'h1234_5678, 1'b1, 1'b1, 8'h5A, 1'b1));
      send_word(mk_word(1'b1, 8'h04, 32'hAAAA_5555, 1'b1, 1'b1, 8'h33, 1'b0));
      send_word(mk_word(1'b0, 8'h04, 32'h0000_0000, 1'b0, 1'b0, 8'h00, 1'b1));
      // kind 00 with one key byte
      send_word(mk_word(1'b1, 8'h00, 32'h0000_0000, 1'b1, 1'b0, 8'hC3, 1'b0));
      send_word(mk_word(1'b0, 8'h00, 32'h0000_0000, 1'b0, 1'b0, 8'h00, 1'b1));
      // after a header the state is kept: this extends the kind 00 record
      send_word(mk_word(1'b0, 8'h00, 32'h0000_0000, 1'b1, 1'b0, 8'h55, 1'b1));
      // expiry record with mixed expiry bytes and value-first payload
      send_word(mk_word(1'b1, KIND_EXP_B, 32'h8001_7FFE, 1'b1, 1'b1, 8'h0F, 1'b0));
      send_word(mk_word(1'b0, 8'h00, 32'h0000_0000, 1'b1, 1'b0, 8'hF0, 1'b1));
   endtask

   initial begin
      framer = new();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // phase 1: sender idles lightly, receiver stalls a lot
      send_idle_pct = 26;
      recv_idle_pct = 64;
      send_directed();
      run_random(48);

      // phase 2: roles swapped
      send_idle_pct = 64;
      recv_idle_pct = 26;
      run_random(48);

      // phase 3: full rate on both sides
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(48);

      req_valid <= 1'b0;

      // drain, then watch a while longer for any extra header byte
      while (framer.pending() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("covered %0d req words, %0d headers, %0d header bytes checked",
               framer.words_seen, framer.headers_built, framer.bytes_checked);
      $display("three idle phases plus directed corner records around the expiry kinds");
      if (framer.fail_count == 0 && framer.pending() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
